// File: rtl/wheel_odometry_integrator_assert.svh
// Assertion macros shared by the odometry RTL files.
`ifndef WHEEL_ODOMETRY_INTEGRATOR_ASSERT_SVH
`define WHEEL_ODOMETRY_INTEGRATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WOI_AST_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("odometry assertion failed");

// Next-cycle implication, checked outside reset.
`define WOI_AST_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("odometry assertion failed");

`endif

// File: rtl/woi_pkg.sv
// Types, constants and helper functions of the wheel odometry integrator.
`default_nettype none
package woi_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int AIDX_W       = 5;
  localparam int MUL_AW       = 32;
  localparam int MUL_BW       = 34;
  localparam int PROD_W       = MUL_AW + MUL_BW;
  localparam int NBITS_W      = 6;
  localparam int CRD_W        = 34;
  localparam int ZW           = 33;

  localparam logic signed [CRD_W-1:0] CORDIC_INIT = 34'sd652032874;
  localparam logic [13:0] ANGLE_SCALE_Q20 = 14'd10937;
  localparam logic [19:0] USEC_PER_SEC    = 20'd1000000;

  typedef struct packed {
    logic               go;
    logic [NBITS_W-1:0] nbits;
  } mul_ctl_t;

  function automatic logic [31:0] atan_lut(input logic [AIDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > PROD_W'(64'sd2147483647))
      r = 32'sh7FFFFFFF;
    else if (v < -PROD_W'(64'sd2147483648))
      r = 32'sh80000000;
    else
      r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/woi_ser_mul.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
`include "wheel_odometry_integrator_assert.svh"
module woi_ser_mul import woi_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mul_ctl_t                 ctl,
  input  wire logic signed [MUL_AW-1:0] a,
  input  wire logic        [MUL_BW-1:0] b,
  output logic                          done,
  output logic signed [PROD_W-1:0]      prod
);

  logic                     busy_r;
  logic                     done_r;
  logic [NBITS_W-1:0]       cnt_r;
  logic signed [PROD_W-1:0] a_sh_r;
  logic [MUL_BW-1:0]        b_sh_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [PROD_W-1:0] addend;
  logic signed [PROD_W-1:0] acc_nxt;

  // Top bit of the multiplier carries negative weight.
  always_comb begin
    addend  = (cnt_r == NBITS_W'(1)) ? -a_sh_r : a_sh_r;
    acc_nxt = b_sh_r[0] ? acc_r + addend : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.go) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - NBITS_W'(1);
        if (cnt_r == NBITS_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      acc_r  <= '0;
      a_sh_r <= PROD_W'(a);
      b_sh_r <= b;
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      a_sh_r <= a_sh_r <<< 1;
      b_sh_r <= b_sh_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

  `WOI_AST_NXT(a_go_starts, clk, rst_n, ctl.go && ctl.nbits != '0, busy_r)
  `WOI_AST_IMP(a_done_idle, clk, rst_n, done_r, !busy_r)
  `WOI_AST_IMP(a_busy_count, clk, rst_n, busy_r, cnt_r != '0)

endmodule
`default_nettype wire

// File: rtl/woi_cordic.sv
// Iterative CORDIC rotator giving cos and sin of a binary angle in Q2.30.
`default_nettype none
`include "wheel_odometry_integrator_assert.svh"
module woi_cordic import woi_pkg::*; #(
  parameter int STAGES = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    go,
  input  wire logic [31:0]             angle,
  output logic                         done,
  output logic signed [CRD_W-1:0]      cos_o,
  output logic signed [CRD_W-1:0]      sin_o
);

  localparam int NITER = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic                    busy_r;
  logic                    done_r;
  logic [AIDX_W-1:0]       i_r;
  logic [1:0]              quad_r;
  logic signed [CRD_W-1:0] x_r, y_r, xn, yn, xs, ys;
  logic signed [ZW-1:0]    z_r, zn, at;
  logic signed [CRD_W-1:0] cos_r, sin_r;
  logic                    last;

  always_comb begin
    xs   = x_r >>> i_r;
    ys   = y_r >>> i_r;
    at   = ZW'(atan_lut(i_r));
    last = (i_r == AIDX_W'(NITER - 1));
    if (!z_r[ZW-1]) begin
      xn = x_r - ys;
      yn = y_r + xs;
      zn = z_r - at;
    end else begin
      xn = x_r + ys;
      yn = y_r - xs;
      zn = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + AIDX_W'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Rotate in the first quadrant, then restore the quadrant on the last step.
  always_ff @(posedge clk) begin
    if (go) begin
      x_r    <= CORDIC_INIT;
      y_r    <= '0;
      z_r    <= ZW'(angle[29:0]);
      quad_r <= angle[31:30];
    end else if (busy_r) begin
      x_r <= xn;
      y_r <= yn;
      z_r <= zn;
      if (last) begin
        case (quad_r)
          QUAD_1:  begin cos_r <= -yn; sin_r <= xn;  end
          QUAD_2:  begin cos_r <= -xn; sin_r <= -yn; end
          QUAD_3:  begin cos_r <= yn;  sin_r <= -xn; end
          default: begin cos_r <= xn;  sin_r <= yn;  end
        endcase
      end
    end
  end

  assign done  = done_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

  `WOI_AST_NXT(a_go_starts, clk, rst_n, go, busy_r)
  `WOI_AST_IMP(a_done_idle, clk, rst_n, done_r, !busy_r)
  `WOI_AST_IMP(a_idx_range, clk, rst_n, busy_r, i_r <= AIDX_W'(NITER - 1))

endmodule
`default_nettype wire

// File: rtl/wheel_odometry_integrator.sv
// Top level of the skid-steer dead-reckoning odometry integrator.
`default_nettype none
`include "wheel_odometry_integrator_assert.svh"
// Dead-reckoning odometry for a four-wheel skid-steer base. Each input transfer
// carries four wheel speeds and a time step in tdata and the active and clear
// flags in tuser; each one yields exactly one output transfer with the updated
// pose and body velocities. A clear or inactive transfer goes straight to the
// final state that loads the output register. An active transfer first runs
// through one bit-serial multiplier (one multiplier bit per cycle, six products
// of 17 to 34 bits), a restoring divide by one million (48 steps, one quotient
// bit per cycle) and a CORDIC rotator that runs beside the divide. Items are
// worked one at a time; a new item is taken as soon as the block is back in
// idle, even while the previous result still waits in the output register. A
// result that is still waiting when the next one is ready holds the sequencer
// in its final state until the output transfer happens. Gains are to be written
// through the plain cfg port only while the block is idle; the block itself does
// not enforce this.
module wheel_odometry_integrator import woi_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // speed_front_left, speed_rear_left, speed_front_right, speed_rear_right,
  // step_time_us
  input  wire logic [79:0]  in_tdata,
  // drives_active, clear_pose
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pos_x, pos_y, heading_angle, linear_velocity, yaw_velocity
  output logic [143:0]      out_tdata
);

  localparam logic [0:0] REG_LINEAR_GAIN = 1'b0;
  localparam logic [0:0] REG_YAW_GAIN    = 1'b1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LIN  = 4'd1;
  localparam logic [3:0] ST_YAW  = 4'd2;
  localparam logic [3:0] ST_ANG  = 4'd3;
  localparam logic [3:0] ST_DMUL = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_PX   = 4'd6;
  localparam logic [3:0] ST_PY   = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  localparam int DIV_N = 48;

  // Configuration and pose state.
  logic signed [31:0] lgain_r, ygain_r;
  logic signed [31:0] pos_x_r, pos_y_r, lin_r, yaw_r;
  logic [31:0]        heading_r;
  logic [3:0]         state_r;

  // Item working registers.
  logic signed [17:0] sum_r;
  logic [15:0]        dt_r;
  logic [29:0]        k_r;
  logic               dneg_r;
  logic [DIV_N-1:0]   m_r;
  logic [19:0]        rem_r;
  logic [28:0]        q_r;
  logic [5:0]         dcnt_r;
  logic signed [31:0] dist_r;

  // Shared multiplier and rotator hookup.
  mul_ctl_t           mul_ctl_r;
  logic signed [31:0] mul_a_r;
  logic [MUL_BW-1:0]  mul_b_r;
  logic               mul_done;
  logic signed [PROD_W-1:0] prod;
  logic               crd_go_r;
  logic               crd_done;
  logic signed [CRD_W-1:0] crd_cos, crd_sin;

  logic               out_tvalid_r;
  logic [143:0]       out_tdata_r;
  logic               mul_wait_st;

  // Unpack the input transfer.
  logic signed [15:0] in_fl, in_rl, in_fr, in_rr;
  logic [15:0]        in_dt;
  logic               in_active, in_clear, in_fire;

  assign in_fl     = in_tdata[15:0];
  assign in_rl     = in_tdata[31:16];
  assign in_fr     = in_tdata[47:32];
  assign in_rr     = in_tdata[63:48];
  assign in_dt     = in_tdata[79:64];
  assign in_active = in_tuser[0];
  assign in_clear  = in_tuser[1];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Rounding and saturation on the multiplier result.
  logic signed [31:0]       lin_new, yaw_new, px_new, py_new, dist_new;
  logic [31:0]              dang;
  logic signed [PROD_W-1:0] nprime, mag, px_add, py_add;
  logic                     nneg;
  logic [20:0]              rem_sh;
  logic                     qbit;
  logic [28:0]              q_fin;

  always_comb begin
    lin_new = sat32((prod + PROD_W'(2048)) >>> 12);
    yaw_new = sat32((PROD_W'(2048) - prod) >>> 12);
    dang    = 32'((prod + PROD_W'(64'd524288)) >>> 20);
    // Floor division of a negative value runs on its magnitude plus divisor minus one.
    nprime  = prod + PROD_W'(USEC_PER_SEC >> 1);
    nneg    = nprime[PROD_W-1];
    mag     = nneg ? (PROD_W'(USEC_PER_SEC) - PROD_W'(1) - nprime) : nprime;
    px_add  = (prod + PROD_W'(64'sd536870912)) >>> 30;
    py_add  = px_add;
    px_new  = sat32(PROD_W'(pos_x_r) + px_add);
    py_new  = sat32(PROD_W'(pos_y_r) + py_add);
    rem_sh  = {rem_r, m_r[DIV_N-1]};
    qbit    = (rem_sh >= 21'(USEC_PER_SEC));
    q_fin   = {q_r[27:0], qbit};
    dist_new = dneg_r ? -$signed(32'(q_fin)) : $signed(32'(q_fin));
  end

  // Gain registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lgain_r <= '0;
      ygain_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LINEAR_GAIN: lgain_r <= cfg_wdata;
        REG_YAW_GAIN:    ygain_r <= cfg_wdata;
        default:         lgain_r <= lgain_r;
      endcase
    end
  end

  // Sequencer: each multiplier state waits for the shared unit, takes its result and
  // launches the next product, if any; the divide state launches one at its last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      heading_r    <= '0;
      lin_r        <= '0;
      yaw_r        <= '0;
      mul_ctl_r    <= '0;
      crd_go_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      mul_ctl_r.go <= 1'b0;
      crd_go_r     <= 1'b0;
      if (out_tvalid_r && out_tready)
        out_tvalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_clear) begin
              pos_x_r   <= '0;
              pos_y_r   <= '0;
              heading_r <= '0;
              lin_r     <= '0;
              yaw_r     <= '0;
              state_r   <= ST_FIN;
            end else if (!in_active) begin
              lin_r   <= '0;
              yaw_r   <= '0;
              state_r <= ST_FIN;
            end else begin
              mul_ctl_r <= '{go: 1'b1, nbits: NBITS_W'(18)};
              state_r   <= ST_LIN;
            end
          end
        end
        ST_LIN: begin
          if (mul_done) begin
            lin_r     <= lin_new;
            mul_ctl_r <= '{go: 1'b1, nbits: NBITS_W'(18)};
            state_r   <= ST_YAW;
          end
        end
        ST_YAW: begin
          if (mul_done) begin
            yaw_r     <= yaw_new;
            mul_ctl_r <= '{go: 1'b1, nbits: NBITS_W'(31)};
            state_r   <= ST_ANG;
          end
        end
        ST_ANG: begin
          if (mul_done) begin
            heading_r <= heading_r + dang;
            crd_go_r  <= 1'b1;
            mul_ctl_r <= '{go: 1'b1, nbits: NBITS_W'(17)};
            state_r   <= ST_DMUL;
          end
        end
        ST_DMUL: begin
          if (mul_done)
            state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (dcnt_r == 6'd1) begin
            mul_ctl_r <= '{go: 1'b1, nbits: NBITS_W'(MUL_BW)};
            state_r   <= ST_PX;
          end
        end
        ST_PX: begin
          if (mul_done) begin
            pos_x_r   <= px_new;
            mul_ctl_r <= '{go: 1'b1, nbits: NBITS_W'(MUL_BW)};
            state_r   <= ST_PY;
          end
        end
        ST_PY: begin
          if (mul_done) begin
            pos_y_r <= py_new;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers: operands, divider and output payload.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        sum_r   <= 18'(in_fl) + 18'(in_rl) + 18'(in_fr) + 18'(in_rr);
        dt_r    <= in_dt;
        k_r     <= 30'(in_dt) * 30'(ANGLE_SCALE_Q20);
        mul_a_r <= lgain_r;
        mul_b_r <= MUL_BW'(18'(in_fl) + 18'(in_rl) - 18'(in_fr) - 18'(in_rr));
      end
      ST_LIN: begin
        mul_a_r <= ygain_r;
        mul_b_r <= MUL_BW'(sum_r);
      end
      ST_YAW: begin
        mul_a_r <= yaw_new;
        mul_b_r <= MUL_BW'(k_r);
      end
      ST_ANG: begin
        mul_a_r <= lin_r;
        mul_b_r <= MUL_BW'(dt_r);
      end
      ST_DMUL: begin
        dneg_r <= nneg;
        m_r    <= mag[DIV_N-1:0];
        rem_r  <= '0;
        q_r    <= '0;
        dcnt_r <= 6'(DIV_N);
      end
      ST_DIV: begin
        // Restoring divide, one quotient bit per cycle.
        rem_r  <= qbit ? 20'(rem_sh - 21'(USEC_PER_SEC)) : rem_sh[19:0];
        m_r    <= m_r << 1;
        q_r    <= q_fin;
        dcnt_r <= dcnt_r - 6'd1;
        dist_r  <= dist_new;
        mul_a_r <= dist_new;
        mul_b_r <= crd_cos;
      end
      ST_PX: begin
        mul_a_r <= dist_r;
        mul_b_r <= crd_sin;
      end
      ST_FIN: begin
        // Hold the waiting result until its transfer frees the output register.
        if (!out_tvalid_r || out_tready)
          out_tdata_r <= {yaw_r, lin_r, heading_r[31:16], pos_y_r, pos_x_r};
      end
      default: dt_r <= dt_r;
    endcase
  end

  woi_ser_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .prod  (prod)
  );

  woi_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (crd_go_r),
    .angle (heading_r),
    .done  (crd_done),
    .cos_o (crd_cos),
    .sin_o (crd_sin)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // States that wait on the shared multiplier.
  assign mul_wait_st = (state_r == ST_LIN) || (state_r == ST_YAW) || (state_r == ST_ANG) ||
                       (state_r == ST_DMUL) || (state_r == ST_PX) || (state_r == ST_PY);

  `WOI_AST_NXT(a_accept_leaves_idle, clk, rst_n, in_tvalid && in_tready, state_r != ST_IDLE)
  `WOI_AST_IMP(a_mul_done_waited, clk, rst_n, mul_done, mul_wait_st)
  `WOI_AST_IMP(a_crd_done_early, clk, rst_n, crd_done, state_r == ST_DMUL || state_r == ST_DIV)
  `WOI_AST_NXT(a_fin_loads, clk, rst_n, state_r == ST_FIN && !out_tvalid_r, out_tvalid_r)

endmodule
`default_nettype wire
